[rtl/core/swps_pkg.sv]
// shared types and constants of the stop-and-wait packet sender
package swps_pkg;

   localparam int PACKET_BYTES_DEFAULT = 1024;
   localparam int HEADER_BYTES         = 5;
   localparam int MID_DEPTH            = 4;
   localparam int RSP_DEPTH            = 4;

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_ONE   = 8'h31;
   localparam logic [7:0] FLAG_CHUNK  = 8'h43;
   localparam logic [7:0] FLAG_FINAL  = 8'h46;
   localparam logic [3:0] DIGIT_FIRST = 4'd1;
   localparam logic [3:0] DIGIT_LAST  = 4'd9;
   localparam logic [3:0] CHECK_SPLIT = 4'd10;

   typedef enum logic [1:0] {
      CMD_BYTE  = 2'd0,
      CMD_EOF   = 2'd1,
      CMD_REPLY = 2'd2,
      CMD_SEND  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_ACCEPT = 2'd0,
      ST_BYTE   = 2'd1,
      ST_REFUSE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_FILL = 2'd0,
      PH_SEND = 2'd1,
      PH_WAIT = 2'd2
   } phase_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic       ack_ok;
   } work_type;

   typedef struct packed {
      status_type status;
      logic [7:0] out_byte;
      logic       last_of_packet;
      logic       is_resend;
      logic       transfer_done;
   } result_type;

   localparam int WORK_BITS   = $bits(work_type);
   localparam int RESULT_BITS = $bits(result_type);

endpackage

[rtl/core/swps_fifo.sv]
// small first-in first-out queue in flip-flops
module swps_fifo
   import swps_pkg::*;
#(
   parameter int WIDTH = WORK_BITS,
   parameter int DEPTH = MID_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTRW = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNTW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/swps_front.sv]
// front end: takes request items, classifies them and queues them for the back end
module swps_front
   import swps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_data_byte,
   input  logic       req_ack_ok,
   input  logic       work_pop,
   output logic       work_empty,
   output work_type   work_item
);

   work_type                 in_item;
   logic [WORK_BITS-1:0]     head_bits;
   logic [$clog2(MID_DEPTH+1)-1:0] mid_count;

   // only the field that the command uses is kept, the rest is cleared
   always_comb begin
      in_item.cmd       = cmd_type'(req_cmd);
      in_item.data_byte = (in_item.cmd == CMD_BYTE) ? req_data_byte : 8'd0;
      in_item.ack_ok    = (in_item.cmd == CMD_REPLY) && req_ack_ok;
   end

   swps_fifo #(
      .WIDTH (WORK_BITS),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (in_item),
      .full      (req_full),
      .pop       (work_pop),
      .pop_data  (head_bits),
      .empty     (work_empty),
      .count     (mid_count)
   );

   assign work_item = work_type'(head_bits);

endmodule

[rtl/core/swps_back.sv]
// back end: protocol state, payload store and packet byte generation
module swps_back
   import swps_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       work_empty,
   input  work_type   work_item,
   output logic       work_pop,
   input  logic       rsp_room,
   output logic       res_push,
   output result_type res_item
);

   localparam int CHUNK_CAP = PACKET_BYTES - HEADER_BYTES;
   localparam int PW        = $clog2(PACKET_BYTES);
   localparam int AW        = $clog2(CHUNK_CAP);
   localparam logic [PW-1:0] CAP_P    = PW'(CHUNK_CAP);
   localparam logic [PW-1:0] HDR_P    = PW'(HEADER_BYTES);
   localparam logic [PW-1:0] HDR_LAST = PW'(HEADER_BYTES - 1);

   phase_type       phase_ff, phase_in;
   logic [PW-1:0]   count_ff, count_in;
   logic [3:0]      sum_ff, sum_in;
   logic [3:0]      seq_ff, seq_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic            final_ff, final_in;
   logic            resend_ff, resend_in;
   logic            s2_valid_ff, s2_valid_in;
   result_type      s2_item_ff, s2_item_in;
   logic            s2_mem_ff, s2_mem_in;
   logic [7:0]      rd_data_ff;
   logic [7:0]      store [CHUNK_CAP];

   logic            issue;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic            rd_en;
   logic [PW-1:0]   pos_off;
   logic [AW-1:0]   rd_addr;
   logic [7:0]      ck_hi;
   logic [7:0]      ck_lo;
   logic [7:0]      hdr_byte;

   assign issue    = !work_empty && rsp_room;
   assign work_pop = issue;
   assign pos_off  = pos_ff - HDR_P;
   assign rd_addr  = pos_off[AW-1:0];
   assign wr_addr  = count_ff[AW-1:0];

   // checksum digits from the low nibble of the byte sum
   always_comb begin
      if (sum_ff == 4'd0) begin
         ck_hi = ASCII_ZERO;
         ck_lo = 8'd0;
      end else if (sum_ff < CHECK_SPLIT) begin
         ck_hi = ASCII_ZERO + {4'd0, sum_ff};
         ck_lo = ASCII_ZERO;
      end else begin
         ck_hi = ASCII_ONE;
         ck_lo = ASCII_ZERO + {4'd0, sum_ff - CHECK_SPLIT};
      end
   end

   always_comb begin
      case (pos_ff)
         PW'(0):  hdr_byte = 8'd0;
         PW'(1):  hdr_byte = ASCII_ZERO + {4'd0, seq_ff};
         PW'(2):  hdr_byte = ck_hi;
         PW'(3):  hdr_byte = ck_lo;
         PW'(4):  hdr_byte = final_ff ? FLAG_FINAL : FLAG_CHUNK;
         default: hdr_byte = 8'd0;
      endcase
   end

   // next state and the result of the item under issue
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      seq_in      = seq_ff;
      pos_in      = pos_ff;
      final_in    = final_ff;
      resend_in   = resend_ff;
      s2_valid_in = issue;
      s2_mem_in   = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      s2_item_in  = '{status: ST_REFUSE, out_byte: 8'd0, last_of_packet: 1'b0,
                      is_resend: 1'b0, transfer_done: 1'b0};
      if (issue) begin
         case (work_item.cmd)
            CMD_BYTE: begin
               if (phase_ff == PH_FILL) begin
                  wr_en             = 1'b1;
                  count_in          = count_ff + 1'b1;
                  sum_in            = sum_ff + work_item.data_byte[3:0];
                  s2_item_in.status = ST_ACCEPT;
                  // chunk full: close it as an ordinary packet
                  if (count_ff + 1'b1 == CAP_P) begin
                     final_in  = 1'b0;
                     resend_in = 1'b0;
                     pos_in    = '0;
                     phase_in  = PH_SEND;
                  end
               end
            end
            CMD_EOF: begin
               if (phase_ff == PH_FILL) begin
                  final_in          = 1'b1;
                  resend_in         = 1'b0;
                  pos_in            = '0;
                  phase_in          = PH_SEND;
                  s2_item_in.status = ST_ACCEPT;
               end
            end
            CMD_SEND: begin
               if (phase_ff == PH_SEND) begin
                  s2_item_in.status    = ST_BYTE;
                  s2_item_in.out_byte  = hdr_byte;
                  s2_item_in.is_resend = resend_ff;
                  s2_mem_in            = (pos_ff >= HDR_P);
                  rd_en                = (pos_ff >= HDR_P);
                  if (pos_ff == count_ff + HDR_LAST) begin
                     s2_item_in.last_of_packet = 1'b1;
                     phase_in                  = PH_WAIT;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                  end
               end
            end
            CMD_REPLY: begin
               if (phase_ff == PH_WAIT) begin
                  s2_item_in.status = ST_ACCEPT;
                  pos_in            = '0;
                  if (work_item.ack_ok) begin
                     if (final_ff) begin
                        s2_item_in.transfer_done = 1'b1;
                        seq_in                   = DIGIT_FIRST;
                     end else begin
                        seq_in = (seq_ff >= DIGIT_LAST) ? DIGIT_FIRST : seq_ff + 1'b1;
                     end
                     count_in  = '0;
                     sum_in    = 4'd0;
                     final_in  = 1'b0;
                     resend_in = 1'b0;
                     phase_in  = PH_FILL;
                  end else begin
                     resend_in = 1'b1;
                     phase_in  = PH_SEND;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FILL;
         count_ff    <= '0;
         sum_ff      <= 4'd0;
         seq_ff      <= DIGIT_FIRST;
         pos_ff      <= '0;
         final_ff    <= 1'b0;
         resend_ff   <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         seq_ff      <= seq_in;
         pos_ff      <= pos_in;
         final_ff    <= final_in;
         resend_ff   <= resend_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_item_ff <= s2_item_in;
      s2_mem_ff  <= s2_mem_in;
   end

   // payload store, one write or one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= work_item.data_byte;
      end
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   always_comb begin
      res_push = s2_valid_ff;
      res_item = s2_item_ff;
      if (s2_mem_ff) begin
         res_item.out_byte = rd_data_ff;
      end
   end

`ifndef SYNTHESIS
   ap_fill_below_cap: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_FILL |-> count_ff < CAP_P)
      else $error("chunk count reached capacity while filling");

   ap_pos_in_packet: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SEND |-> pos_ff <= count_ff + HDR_LAST)
      else $error("send position beyond end of packet");

   ap_seq_digit: assert property (@(posedge clock) disable iff (reset)
      seq_ff >= DIGIT_FIRST && seq_ff <= DIGIT_LAST)
      else $error("sequence digit out of range");

   ap_issue_result: assert property (@(posedge clock) disable iff (reset)
      issue |=> res_push)
      else $error("issued item produced no result");

   ap_last_to_wait: assert property (@(posedge clock) disable iff (reset)
      issue && phase_ff == PH_SEND && work_item.cmd == CMD_SEND
      && pos_ff == count_ff + HDR_LAST |=> phase_ff == PH_WAIT)
      else $error("last byte did not move to awaiting reply");
`endif

endmodule

[rtl/core/stop_and_wait_packet_sender_top.sv]
// top level of the stop-and-wait packet sender
//
// stop-and-wait packet sender. items come in through a queue-style port
// (req_push / req_full) and results leave through another (rsp_empty / rsp_pop);
// every item produces exactly one result. payload bytes (cmd 0) fill a chunk
// store of PACKET_BYTES-5 entries; the chunk closes as a 'C' packet when full or
// as an 'F' packet on end of file (cmd 1). transmit commands (cmd 3) then return
// the packet one byte per item: zero byte, sequence digit, two checksum bytes,
// flag, payload. a reply (cmd 2) either re-arms the packet for resending or
// advances the sequence digit (back to 1 after 9 or after the final packet)
// and reopens the store. commands in the wrong phase come back with status 2.
// throughput is one item per clock when the result side keeps popping; an
// item is written into the front queue, its result is then registered in the
// issue stage together with the registered read of the payload store and
// then written into the result queue, whose head drives the result ports.
// the payload store carries one write or one read per item, which sets that
// one-per-clock figure. the store needs no clearing after reset.
module stop_and_wait_packet_sender_top
   import swps_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // input item channel
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_data_byte,
   input  logic       req_ack_ok,
   // result item channel
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_packet,
   output logic       rsp_is_resend,
   output logic       rsp_transfer_done
);

   localparam int RCW = $clog2(RSP_DEPTH + 1);

   // front to back queue
   logic       work_empty;
   work_type   work_item;
   logic       work_pop;

   // back to result queue
   logic                   res_push;
   result_type             res_item;
   logic                   res_full;
   logic [RESULT_BITS-1:0] rsp_bits;
   result_type             rsp_item;
   logic [RCW-1:0]         rsp_count;
   logic                   rsp_room;

   swps_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .req_ack_ok    (req_ack_ok),
      .work_pop      (work_pop),
      .work_empty    (work_empty),
      .work_item     (work_item)
   );

   // the back end keeps one result in flight, so it issues only while the
   // result queue has room for that one plus the new one
   assign rsp_room = (rsp_count <= RCW'(RSP_DEPTH - 2));

   swps_back #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .work_empty (work_empty),
      .work_item  (work_item),
      .work_pop   (work_pop),
      .rsp_room   (rsp_room),
      .res_push   (res_push),
      .res_item   (res_item)
   );

   // result queue: parts the back end from the consumer
   swps_fifo #(
      .WIDTH (RESULT_BITS),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_item),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty),
      .count     (rsp_count)
   );

   assign rsp_item           = result_type'(rsp_bits);
   assign rsp_status         = rsp_item.status;
   assign rsp_out_byte       = rsp_item.out_byte;
   assign rsp_last_of_packet = rsp_item.last_of_packet;
   assign rsp_is_resend      = rsp_item.is_resend;
   assign rsp_transfer_done  = rsp_item.transfer_done;

`ifndef SYNTHESIS
   ap_no_result_overflow: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result queue overflow");

   ap_room_tracks_count: assert property (@(posedge clock) disable iff (reset)
      !rsp_room |-> rsp_count >= RCW'(RSP_DEPTH - 1))
      else $error("issue held back with room in result queue");

   ap_pop_needs_result: assert property (@(posedge clock) disable iff (reset)
      work_pop |-> !work_empty)
      else $error("back end popped an empty work queue");
`endif

endmodule
